// ===== rtl/gf2_7_field_alu_macros.svh =====
// Assertion macros for the GF(2^7) ALU.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef GF2_7_FIELD_ALU_MACROS_SVH
`define GF2_7_FIELD_ALU_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GF27_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define GF27_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define GF27_ASSERT_IMPL(lbl, ante, cons, msg)

`define GF27_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/gf27_pkg.sv =====
package gf27_pkg;

	localparam int unsigned ELEM_W = 7;
	localparam int unsigned OP_W   = 2;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_MUL = 2'd1;
	localparam logic [OP_W-1:0] OP_INV = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;

	// x^7 + x + 1
	localparam logic [ELEM_W-1:0] TAIL_RESET = 7'd3;

	typedef logic [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		elem_t           a;
		elem_t           b;
	} side_t;

	// shift-and-add product, reduced by x^7 + tail
	function automatic elem_t gf_mul(input elem_t a, input elem_t b, input elem_t tail);
		elem_t acc;
		acc = '0;
		for (int k = ELEM_W - 1; k >= 0; k--) begin
			acc = {acc[ELEM_W-2:0], 1'b0} ^ (acc[ELEM_W-1] ? tail : elem_t'(0));
			if (b[k]) begin
				acc = acc ^ a;
			end
		end
		return acc;
	endfunction

endpackage

// ===== rtl/gf27_pow.sv =====
// base^126 over nine stages, one field multiply per stage:
// a^2, a^3, a^6, a^12, a^15, a^30, a^60, a^63, a^126
module gf27_pow (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  gf27_pkg::elem_t tail,
	input  logic            in_valid,
	input  gf27_pkg::elem_t in_base,
	input  gf27_pkg::side_t in_side,
	output logic            out_valid,
	output gf27_pkg::elem_t out_pow,
	output gf27_pkg::side_t out_side
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	gf27_pkg::elem_t base_s1;
	gf27_pkg::elem_t pw_s1, pw_s2, pw_s3, pw_s4, pw_s5, pw_s6, pw_s7, pw_s8, pw_s9;
	gf27_pkg::elem_t cube_s2, cube_s3, cube_s4, cube_s5, cube_s6, cube_s7;
	gf27_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	gf27_pkg::side_t side_s6, side_s7, side_s8, side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			base_s1 <= in_base;
			pw_s1   <= gf27_pkg::gf_mul(in_base, in_base, tail);
			side_s1 <= in_side;

			pw_s2   <= gf27_pkg::gf_mul(pw_s1, base_s1, tail);
			cube_s2 <= gf27_pkg::gf_mul(pw_s1, base_s1, tail);
			side_s2 <= side_s1;

			pw_s3   <= gf27_pkg::gf_mul(pw_s2, pw_s2, tail);
			cube_s3 <= cube_s2;
			side_s3 <= side_s2;

			pw_s4   <= gf27_pkg::gf_mul(pw_s3, pw_s3, tail);
			cube_s4 <= cube_s3;
			side_s4 <= side_s3;

			pw_s5   <= gf27_pkg::gf_mul(pw_s4, cube_s4, tail);
			cube_s5 <= cube_s4;
			side_s5 <= side_s4;

			pw_s6   <= gf27_pkg::gf_mul(pw_s5, pw_s5, tail);
			cube_s6 <= cube_s5;
			side_s6 <= side_s5;

			pw_s7   <= gf27_pkg::gf_mul(pw_s6, pw_s6, tail);
			cube_s7 <= cube_s6;
			side_s7 <= side_s6;

			pw_s8   <= gf27_pkg::gf_mul(pw_s7, cube_s7, tail);
			side_s8 <= side_s7;

			pw_s9   <= gf27_pkg::gf_mul(pw_s8, pw_s8, tail);
			side_s9 <= side_s8;
		end
	end

	assign out_valid = valid_s9;
	assign out_pow   = pw_s9;
	assign out_side  = side_s9;

endmodule

// ===== rtl/gf2_7_field_alu.sv =====
// GF(2^7) ALU: add, multiply, inverse (a^126), divide (a * b^126, or a when b is zero).
// Throughput: one transaction per cycle; nine power stages and one final
// multiply/select stage, all advancing together when the output is free.
// Reset: arst_n clears all valid bits and loads the polynomial tail with 3.
`include "gf2_7_field_alu_macros.svh"

module gf2_7_field_alu (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [6:0] operand_a,
	input  logic [6:0] operand_b,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] field_result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] field_polynomial_tail
);

	gf27_pkg::elem_t tail_q;
	logic            advance;
	gf27_pkg::elem_t in_base;
	gf27_pkg::side_t in_side;

	logic            pow_valid;
	gf27_pkg::elem_t pow_val;
	gf27_pkg::side_t pow_side;

	gf27_pkg::elem_t mul_rhs;
	gf27_pkg::elem_t mul_val;
	gf27_pkg::elem_t result_nxt;

	logic            valid_s10;
	gf27_pkg::elem_t result_s10;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= gf27_pkg::TAIL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tail_q <= field_polynomial_tail;
		end
	end

	assign advance  = !(valid_s10 && out_stall);
	assign in_stall = !advance;

	assign in_base        = (opcode == gf27_pkg::OP_DIV) ? operand_b : operand_a;
	assign in_side.opcode = opcode;
	assign in_side.a      = operand_a;
	assign in_side.b      = operand_b;

	gf27_pow u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.tail      (tail_q),
		.in_valid  (in_valid),
		.in_base   (in_base),
		.in_side   (in_side),
		.out_valid (pow_valid),
		.out_pow   (pow_val),
		.out_side  (pow_side)
	);

	assign mul_rhs = (pow_side.opcode == gf27_pkg::OP_MUL) ? pow_side.b : pow_val;
	assign mul_val = gf27_pkg::gf_mul(pow_side.a, mul_rhs, tail_q);

	always_comb begin
		unique case (pow_side.opcode)
			gf27_pkg::OP_ADD: result_nxt = pow_side.a ^ pow_side.b;
			gf27_pkg::OP_MUL: result_nxt = mul_val;
			gf27_pkg::OP_INV: result_nxt = pow_val;
			gf27_pkg::OP_DIV: result_nxt = (pow_side.b == '0) ? pow_side.a : mul_val;
			default:          result_nxt = mul_val;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (advance) begin
			valid_s10 <= pow_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s10 <= result_nxt;
		end
	end

	assign out_valid    = valid_s10;
	assign field_result = result_s10;

	`GF27_ASSERT_NEXT(a_pipe_hold, pow_valid && !advance, pow_valid, "pipe dropped item on stall")
	`GF27_ASSERT_NEXT(a_add_xor, pow_valid && advance && pow_side.opcode == gf27_pkg::OP_ADD, out_valid && field_result == $past(pow_side.a ^ pow_side.b), "add result wrong")
	`GF27_ASSERT_NEXT(a_inv_zero, pow_valid && advance && pow_side.opcode == gf27_pkg::OP_INV && pow_side.a == '0, out_valid && field_result == '0, "inverse of zero not zero")

endmodule
